>>> design/scp_pkg.sv
// Shared widths and stage types for the segment crossing point unit.
package scp_pkg;

  // Coordinate width and the widths derived from it.
  localparam int COORD_WIDTH = 16;
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int SUM_W       = PROD_W + 1;
  localparam int WIDE_W      = SUM_W + DIFF_W + 1;

  // Cross product results handed from the cross stage to the scale stage.
  typedef struct packed {
    logic                     valid;
    logic                     hit;
    logic signed [SUM_W-1:0]  det;
    logic signed [SUM_W-1:0]  num;
    logic signed [COORD_WIDTH-1:0] bx;
    logic signed [COORD_WIDTH-1:0] by;
    logic signed [DIFF_W-1:0] abx;
    logic signed [DIFF_W-1:0] aby;
  } cross_t;

  // Divider stage contents: both coordinates share the shifted divisor.
  typedef struct packed {
    logic                   valid;
    logic                   hit;
    logic                   neg_x;
    logic                   neg_y;
    logic [WIDE_W-1:0]      rem_x;
    logic [WIDE_W-1:0]      rem_y;
    logic [WIDE_W-1:0]      dsh;
    logic [COORD_WIDTH-1:0] q_x;
    logic [COORD_WIDTH-1:0] q_y;
  } div_t;

endpackage

>>> design/scp_cross.sv
// Three-stage datapath that forms the differences, products and cross products.
module scp_cross (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic signed [scp_pkg::COORD_WIDTH-1:0] ax,
  input  logic signed [scp_pkg::COORD_WIDTH-1:0] ay,
  input  logic signed [scp_pkg::COORD_WIDTH-1:0] bx,
  input  logic signed [scp_pkg::COORD_WIDTH-1:0] by,
  input  logic signed [scp_pkg::COORD_WIDTH-1:0] cx,
  input  logic signed [scp_pkg::COORD_WIDTH-1:0] cy,
  input  logic signed [scp_pkg::COORD_WIDTH-1:0] dx,
  input  logic signed [scp_pkg::COORD_WIDTH-1:0] dy,
  output scp_pkg::cross_t                        cr_o
);

  localparam int W  = scp_pkg::COORD_WIDTH;
  localparam int DW = scp_pkg::DIFF_W;
  localparam int PW = scp_pkg::PROD_W;
  localparam int SW = scp_pkg::SUM_W;

  // Stage 1 registers: coordinate differences.
  logic                 v1_r;
  logic signed [W-1:0]  bx1_r, by1_r;
  logic signed [DW-1:0] cxdx_r, aycy_r, cydy_r, cxax_r, bycy_r, cxbx_r, axbx_r;
  logic signed [DW-1:0] cyay_r, ayby_r, axcx_r, dyay_r, axdx_r, dycy_r, dxbx_r, dyby_r;

  // Stage 2 registers: partial products.
  logic                 v2_r;
  logic signed [W-1:0]  bx2_r, by2_r;
  logic signed [DW-1:0] abx2_r, aby2_r;
  logic signed [PW-1:0] pa0_r, pa1_r, pb0_r, pb1_r, pc0_r, pc1_r;
  logic signed [PW-1:0] pd0_r, pd1_r, pe0_r, pe1_r, pn0_r, pn1_r;

  // Stage 3 combinational sums.
  logic signed [SW-1:0] ta, tb, tc, td, det, num;
  logic                 straddle_ab, straddle_cd;
  scp_pkg::cross_t      cr_r, cr_nxt;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      cr_r.valid <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      cr_r.valid <= v2_r;
    end
  end

  // Stage 1: sixteen-bit coordinates widened by one bit before subtracting.
  always_ff @(posedge clk) begin
    if (en) begin
      bx1_r  <= bx;
      by1_r  <= by;
      cxdx_r <= DW'(cx) - DW'(dx);
      aycy_r <= DW'(ay) - DW'(cy);
      cydy_r <= DW'(cy) - DW'(dy);
      cxax_r <= DW'(cx) - DW'(ax);
      bycy_r <= DW'(by) - DW'(cy);
      cxbx_r <= DW'(cx) - DW'(bx);
      axbx_r <= DW'(ax) - DW'(bx);
      cyay_r <= DW'(cy) - DW'(ay);
      ayby_r <= DW'(ay) - DW'(by);
      axcx_r <= DW'(ax) - DW'(cx);
      dyay_r <= DW'(dy) - DW'(ay);
      axdx_r <= DW'(ax) - DW'(dx);
      dycy_r <= DW'(dy) - DW'(cy);
      dxbx_r <= DW'(dx) - DW'(bx);
      dyby_r <= DW'(dy) - DW'(by);
    end
  end

  // Stage 2: twelve small signed products.
  always_ff @(posedge clk) begin
    if (en) begin
      bx2_r  <= bx1_r;
      by2_r  <= by1_r;
      abx2_r <= axbx_r;
      aby2_r <= ayby_r;
      pa0_r  <= cxdx_r * aycy_r;
      pa1_r  <= cydy_r * cxax_r;
      pb0_r  <= cxdx_r * bycy_r;
      pb1_r  <= cydy_r * cxbx_r;
      pc0_r  <= axbx_r * cyay_r;
      pc1_r  <= ayby_r * axcx_r;
      pd0_r  <= axbx_r * dyay_r;
      pd1_r  <= ayby_r * axdx_r;
      pe0_r  <= axbx_r * dycy_r;
      pe1_r  <= cxdx_r * ayby_r;
      pn0_r  <= dycy_r * dxbx_r;
      pn1_r  <= cxdx_r * dyby_r;
    end
  end

  // Stage 3: side products, determinant and the strict straddle test.
  always_comb begin
    ta  = SW'(pa0_r) + SW'(pa1_r);
    tb  = SW'(pb0_r) + SW'(pb1_r);
    tc  = SW'(pc0_r) + SW'(pc1_r);
    td  = SW'(pd0_r) + SW'(pd1_r);
    det = SW'(pe0_r) + SW'(pe1_r);
    num = SW'(pn0_r) + SW'(pn1_r);
    straddle_ab = (ta != '0) && (tb != '0) && (ta[SW-1] != tb[SW-1]);
    straddle_cd = (tc != '0) && (td != '0) && (tc[SW-1] != td[SW-1]);
    cr_nxt       = cr_r;
    cr_nxt.hit   = straddle_ab && straddle_cd && (det != '0);
    cr_nxt.det   = det;
    cr_nxt.num   = num;
    cr_nxt.bx    = bx2_r;
    cr_nxt.by    = by2_r;
    cr_nxt.abx   = abx2_r;
    cr_nxt.aby   = aby2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cr_r.hit <= cr_nxt.hit;
      cr_r.det <= cr_nxt.det;
      cr_r.num <= cr_nxt.num;
      cr_r.bx  <= cr_nxt.bx;
      cr_r.by  <= cr_nxt.by;
      cr_r.abx <= cr_nxt.abx;
      cr_r.aby <= cr_nxt.aby;
    end
  end

  assign cr_o = cr_r;

endmodule

>>> design/scp_scale.sv
// Two stages that scale the cross products into numerators and set up the divider.
module scp_scale (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  scp_pkg::cross_t cr_i,
  output scp_pkg::div_t   dv_o
);

  localparam int W  = scp_pkg::COORD_WIDTH;
  localparam int SW = scp_pkg::SUM_W;
  localparam int XW = scp_pkg::WIDE_W;

  // Stage 4 registers: the four wide products.
  logic                      v4_r, hit4_r;
  logic signed [SW-1:0]      det4_r;
  logic signed [SW+W-1:0]    pbx_r, pby_r;
  logic signed [XW-2:0]      pnx_r, pny_r;

  // Stage 5 combinational values.
  logic signed [XW-1:0]      nx, ny;
  logic [SW-1:0]             det_mag;
  scp_pkg::div_t             dv_r, dv_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      dv_r.valid <= 1'b0;
    end else if (en) begin
      v4_r <= cr_i.valid;
      dv_r.valid <= v4_r;
    end
  end

  // Stage 4: determinant times B and numerator times (A - B).
  always_ff @(posedge clk) begin
    if (en) begin
      hit4_r <= cr_i.hit;
      det4_r <= cr_i.det;
      pbx_r  <= cr_i.det * cr_i.bx;
      pby_r  <= cr_i.det * cr_i.by;
      pnx_r  <= cr_i.num * cr_i.abx;
      pny_r  <= cr_i.num * cr_i.aby;
    end
  end

  // Stage 5: full numerators, magnitudes and the divisor aligned to the top quotient bit.
  always_comb begin
    nx      = XW'(pbx_r) + XW'(pnx_r);
    ny      = XW'(pby_r) + XW'(pny_r);
    det_mag = det4_r[SW-1] ? SW'(-det4_r) : SW'(det4_r);
    dv_nxt        = dv_r;
    dv_nxt.hit    = hit4_r;
    dv_nxt.neg_x  = nx[XW-1] ^ det4_r[SW-1];
    dv_nxt.neg_y  = ny[XW-1] ^ det4_r[SW-1];
    dv_nxt.rem_x  = nx[XW-1] ? XW'(-nx) : XW'(nx);
    dv_nxt.rem_y  = ny[XW-1] ? XW'(-ny) : XW'(ny);
    dv_nxt.dsh    = XW'(det_mag) << (W - 1);
    dv_nxt.q_x    = '0;
    dv_nxt.q_y    = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r.hit   <= dv_nxt.hit;
      dv_r.neg_x <= dv_nxt.neg_x;
      dv_r.neg_y <= dv_nxt.neg_y;
      dv_r.rem_x <= dv_nxt.rem_x;
      dv_r.rem_y <= dv_nxt.rem_y;
      dv_r.dsh   <= dv_nxt.dsh;
      dv_r.q_x   <= dv_nxt.q_x;
      dv_r.q_y   <= dv_nxt.q_y;
    end
  end

  assign dv_o = dv_r;

endmodule

>>> design/scp_div_step.sv
// One registered step of the restoring divider: one quotient bit for x and for y.
module scp_div_step (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  scp_pkg::div_t dv_i,
  output scp_pkg::div_t dv_o
);

  localparam int W = scp_pkg::COORD_WIDTH;

  logic          take_x, take_y;
  scp_pkg::div_t dv_r, dv_nxt;

  // Subtract the shifted divisor where it fits, then move it down one place.
  always_comb begin
    take_x = dv_i.rem_x >= dv_i.dsh;
    take_y = dv_i.rem_y >= dv_i.dsh;
    dv_nxt       = dv_i;
    dv_nxt.rem_x = take_x ? dv_i.rem_x - dv_i.dsh : dv_i.rem_x;
    dv_nxt.rem_y = take_y ? dv_i.rem_y - dv_i.dsh : dv_i.rem_y;
    dv_nxt.q_x   = {dv_i.q_x[W-2:0], take_x};
    dv_nxt.q_y   = {dv_i.q_y[W-2:0], take_y};
    dv_nxt.dsh   = dv_i.dsh >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r.valid <= 1'b0;
    end else if (en) begin
      dv_r.valid <= dv_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r.hit   <= dv_nxt.hit;
      dv_r.neg_x <= dv_nxt.neg_x;
      dv_r.neg_y <= dv_nxt.neg_y;
      dv_r.rem_x <= dv_nxt.rem_x;
      dv_r.rem_y <= dv_nxt.rem_y;
      dv_r.dsh   <= dv_nxt.dsh;
      dv_r.q_x   <= dv_nxt.q_x;
      dv_r.q_y   <= dv_nxt.q_y;
    end
  end

  assign dv_o = dv_r;

endmodule

>>> design/segment_crossing_point_unit.sv
// Top level: strict 2D segment crossing test with exact crossing point.
// Pipeline: an accepted input transaction reaches its result through 3 cross stages,
// 2 scale stages, one divider stage per coordinate bit and one output register.
// Throughput: one transaction per cycle; a stalled output freezes the whole pipeline.
// Reset: synchronous active-low rst_n clears every stage valid bit and the output valid.
module segment_crossing_point_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [scp_pkg::COORD_WIDTH-1:0] in_point_a_x,
  input  logic signed [scp_pkg::COORD_WIDTH-1:0] in_point_a_y,
  input  logic signed [scp_pkg::COORD_WIDTH-1:0] in_point_b_x,
  input  logic signed [scp_pkg::COORD_WIDTH-1:0] in_point_b_y,
  input  logic signed [scp_pkg::COORD_WIDTH-1:0] in_point_c_x,
  input  logic signed [scp_pkg::COORD_WIDTH-1:0] in_point_c_y,
  input  logic signed [scp_pkg::COORD_WIDTH-1:0] in_point_d_x,
  input  logic signed [scp_pkg::COORD_WIDTH-1:0] in_point_d_y,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   out_hit,
  output logic signed [scp_pkg::COORD_WIDTH-1:0] out_cross_x,
  output logic signed [scp_pkg::COORD_WIDTH-1:0] out_cross_y
);

  localparam int W = scp_pkg::COORD_WIDTH;

  logic                   en;
  scp_pkg::cross_t        cr;
  scp_pkg::div_t          stg [0:W];
  logic                   out_valid_r, out_hit_r;
  logic signed [W-1:0]    out_cross_x_r, out_cross_y_r;
  logic signed [W-1:0]    cross_x_nxt, cross_y_nxt;

  // The pipeline advances whenever the output register is free to take a result.
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  scp_cross u_cross (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .ax       (in_point_a_x),
    .ay       (in_point_a_y),
    .bx       (in_point_b_x),
    .by       (in_point_b_y),
    .cx       (in_point_c_x),
    .cy       (in_point_c_y),
    .dx       (in_point_d_x),
    .dy       (in_point_d_y),
    .cr_o     (cr)
  );

  scp_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .cr_i  (cr),
    .dv_o  (stg[0])
  );

  // One divider step per quotient bit, most significant first.
  for (genvar i = 0; i < W; i++) begin : g_div
    scp_div_step u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .dv_i  (stg[i]),
      .dv_o  (stg[i+1])
    );
  end

  // Apply the quotient sign; a miss reports the origin.
  always_comb begin
    cross_x_nxt = stg[W].neg_x ? -$signed(stg[W].q_x) : $signed(stg[W].q_x);
    cross_y_nxt = stg[W].neg_y ? -$signed(stg[W].q_y) : $signed(stg[W].q_y);
    if (!stg[W].hit) begin
      cross_x_nxt = '0;
      cross_y_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= stg[W].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hit_r     <= stg[W].hit;
      out_cross_x_r <= cross_x_nxt;
      out_cross_y_r <= cross_y_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_hit     = out_hit_r;
  assign out_cross_x = out_cross_x_r;
  assign out_cross_y = out_cross_y_r;

  // A miss always reports a zero point.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_cross_x == '0 && out_cross_y == '0)
    else $error("miss transaction with nonzero point");

  // Input is held back exactly while a finished result waits.
  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output backpressure");

  // Nothing comes out in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("output valid right after reset");

endmodule
